// ===== hw/rtl/escc_pkg.sv =====
// Shared constants, types and calendar table for the epoch seconds calendar converter.
// Used by escc_encode, escc_decode and epoch_seconds_calendar_convert.
package escc_pkg;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 80;
    localparam int PIPE_DEPTH = 9;
    localparam int ENC_STAGES = 3;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [11:0] YEAR_FIRST    = 12'd1970;
    localparam logic [11:0] YEAR_LAST     = 12'd2038;
    localparam logic [3:0]  MONTH_LAST    = 4'd12;
    localparam logic [7:0]  BASE_YEAR     = 8'd70;
    localparam logic [1:0]  LEAP_SLOT     = 2'd2;
    localparam logic [17:0] DAY_SECS      = 18'd86400;
    localparam logic [9:0]  DAY_SECS_HI   = 10'd675;
    localparam logic [10:0] QUAD_DAYS     = 11'd1461;
    localparam logic [8:0]  YEAR_DAYS     = 9'd365;
    localparam logic [10:0] TWO_YEAR_DAYS = 11'd730;
    localparam logic [10:0] LEAP_END_DAYS = 11'd1096;
    localparam logic [11:0] HOUR_SECS     = 12'd3600;
    localparam logic [5:0]  MIN_SECS      = 6'd60;
    localparam logic [2:0]  WEEK_DAYS     = 3'd7;
    localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;
    localparam logic [4:0]  HOUR_MAX      = 5'd23;
    localparam logic [5:0]  MIN_MAX       = 6'd59;
    localparam logic [3:0]  MONTH_IDX_MAX = 4'd11;
    localparam logic [2:0]  WEEKDAY_MAX   = 3'd6;

    localparam logic [15:0] DAY_RCP  = 16'((1 << 25) / 675);
    localparam logic [5:0]  QUAD_RCP = 6'((1 << 16) / 1461);
    localparam logic [13:0] WEEK_RCP = 14'((1 << 16) / 7);
    localparam logic [5:0]  HOUR_RCP = 6'((1 << 17) / 3600);
    localparam logic [6:0]  MIN_RCP  = 7'((1 << 12) / 60);

    typedef struct packed {
        logic [5:0]  second_in;
        logic [5:0]  minute_in;
        logic [4:0]  hour_in;
        logic [4:0]  day_in;
        logic [3:0]  month_in;
        logic [11:0] full_year;
    } t_enc_in;

    typedef struct packed {
        logic [5:0] second_out;
        logic [5:0] minute_out;
        logic [4:0] hour_out;
        logic [2:0] weekday;
        logic [8:0] day_of_year;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [7:0] years_since_1900;
    } t_dec_res;

    function automatic logic [8:0] days_before(input logic [3:0] month_idx, input logic leap);
        logic [8:0] base;
        logic [8:0] adj;
        case (month_idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        adj = (leap && month_idx >= 4'd2) ? 9'd1 : 9'd0;
        return base + adj;
    endfunction

endpackage

// ===== hw/rtl/epoch_seconds_calendar_convert.sv =====
// Converts between UTC calendar fields and seconds since 1970, direction chosen per beat by
// the opcode in s_axis_tuser. One beat is taken every cycle unless stalled. Each result
// passes the input register, nine arithmetic stages and the output register. A stall on the
// master side freezes the whole pipeline, so s_axis_tready follows m_axis_tready one for one
// once the output register is full. Decoding treats every fourth year as leap, exact through 2099.
module epoch_seconds_calendar_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // full_year[11:0], month_in[15:12], day_in[20:16], hour_in[25:21],
    // minute_in[31:26], second_in[37:32], epoch_in[70:38], zero[71]
    input  logic [escc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // epoch_out[31:0], years_since_1900[39:32], month_index[43:40], day_of_month[48:44],
    // day_of_year[57:49], weekday[60:58], hour_out[65:61], minute_out[71:66],
    // second_out[77:72], zero[79:78]
    output logic [escc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // valid_res[0]
    output logic [0:0]  m_axis_tuser
);

    localparam int DEPTH = escc_pkg::PIPE_DEPTH;

    logic                            adv;
    logic                            r_in_valid;
    logic                            r_in_op;
    logic [escc_pkg::IN_DATA_W-1:0]  r_in_data;
    logic [DEPTH-1:0]                r_vld;
    logic [DEPTH-1:0]                r_op;
    logic                            r_out_valid;
    logic                            r_out_op;
    logic [escc_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                            r_out_ok;
    logic                            n_out_ok;
    logic [escc_pkg::OUT_DATA_W-1:0] n_out_data;
    logic                            enc_ok;
    logic [31:0]                     enc_epoch;
    logic                            dec_ok;
    escc_pkg::t_dec_res              dec_res;
    escc_pkg::t_enc_in               enc_in;

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign enc_in        = escc_pkg::t_enc_in'(r_in_data[37:0]);

    escc_encode u_encode (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_fields (enc_in),
        .o_ok     (enc_ok),
        .o_epoch  (enc_epoch)
    );

    escc_decode u_decode (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_epoch (r_in_data[70:38]),
        .o_ok    (dec_ok),
        .o_res   (dec_res)
    );

    always_comb begin
        n_out_ok   = 1'b0;
        n_out_data = '0;
        if (r_op[DEPTH-1] == escc_pkg::OP_ENCODE) begin
            if (enc_ok) begin
                n_out_ok         = 1'b1;
                n_out_data[31:0] = enc_epoch;
            end
        end else begin
            if (dec_ok) begin
                n_out_ok          = 1'b1;
                n_out_data[77:32] = dec_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid  <= s_axis_tvalid;
            r_vld       <= {r_vld[DEPTH-2:0], r_in_valid};
            r_out_valid <= r_vld[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in_data  <= s_axis_tdata;
            r_in_op    <= s_axis_tuser[0];
            r_op       <= {r_op[DEPTH-2:0], r_in_op};
            r_out_op   <= r_op[DEPTH-1];
            r_out_ok   <= n_out_ok;
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_ok;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_data == '0))
        else $error("failed conversion carries non-zero fields");

    a_dec_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ok && r_out_op == escc_pkg::OP_DECODE)
        |-> (r_out_data[43:40] <= escc_pkg::MONTH_IDX_MAX && r_out_data[48:44] != 5'd0
             && r_out_data[60:58] <= escc_pkg::WEEKDAY_MAX))
        else $error("decoded date field out of range");

    a_dec_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ok && r_out_op == escc_pkg::OP_DECODE)
        |-> (r_out_data[65:61] <= escc_pkg::HOUR_MAX && r_out_data[71:66] <= escc_pkg::MIN_MAX
             && r_out_data[77:72] <= escc_pkg::MIN_MAX && r_out_data[31:0] == 32'd0))
        else $error("decoded time field out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_vld) && $stable(r_in_valid)))
        else $error("pipeline moved during stall");

endmodule

// ===== hw/rtl/escc_encode.sv =====
// Calendar fields to epoch seconds: three arithmetic stages, then a delay line
// to match the decode latency. Depends on escc_pkg.
module escc_encode (
    input  logic               i_clk,
    input  logic               i_en,
    input  escc_pkg::t_enc_in  i_fields,
    output logic               o_ok,
    output logic [31:0]        o_epoch
);

    localparam int DLY = escc_pkg::PIPE_DEPTH - escc_pkg::ENC_STAGES;

    typedef struct packed {
        logic        ok;
        logic [31:0] epoch;
    } t_enc_res;

    logic [11:0]        yoff;
    logic [6:0]         y;
    logic               leap;
    logic [3:0]         mi;
    logic [14:0]        ysum;
    logic [16:0]        hms;
    logic               in_ok;
    logic signed [33:0] prod;
    logic signed [33:0] tsum;

    logic signed [15:0] r1_days;
    logic [16:0]        r1_hms;
    logic               r1_ok;
    logic signed [33:0] r2_prod;
    logic [16:0]        r2_hms;
    logic               r2_ok;
    t_enc_res           r3_res;
    t_enc_res           r_dly [DLY];

    always_comb begin
        yoff  = i_fields.full_year - escc_pkg::YEAR_FIRST;
        y     = yoff[6:0];
        leap  = (y[1:0] == escc_pkg::LEAP_SLOT);
        mi    = i_fields.month_in - 4'd1;
        in_ok = (i_fields.full_year >= escc_pkg::YEAR_FIRST)
             && (i_fields.full_year <= escc_pkg::YEAR_LAST)
             && (i_fields.month_in != 4'd0)
             && (i_fields.month_in <= escc_pkg::MONTH_LAST);
        ysum  = 15'(15'(y) * 15'(escc_pkg::YEAR_DAYS))
              + 15'((8'(y) + 8'd1) >> 2)
              + 15'(escc_pkg::days_before(mi, leap))
              + 15'(i_fields.day_in);
        hms   = 17'(17'(i_fields.hour_in) * 17'(escc_pkg::HOUR_SECS))
              + 17'(17'(i_fields.minute_in) * 17'(escc_pkg::MIN_SECS))
              + 17'(i_fields.second_in);
        prod  = 34'(r1_days) * $signed({16'd0, escc_pkg::DAY_SECS});
        tsum  = r2_prod + $signed({17'd0, r2_hms});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_days      <= $signed({1'b0, ysum}) - 16'sd1;
            r1_hms       <= hms;
            r1_ok        <= in_ok;
            r2_prod      <= prod;
            r2_hms       <= r1_hms;
            r2_ok        <= r1_ok;
            r3_res.ok    <= r2_ok && !tsum[33];
            r3_res.epoch <= tsum[31:0];
            r_dly[0]     <= r3_res;
            for (int i = 1; i < DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    assign o_ok    = r_dly[DLY-1].ok;
    assign o_epoch = r_dly[DLY-1].epoch;

endmodule

// ===== hw/rtl/escc_decode.sv =====
// Epoch seconds to broken-down UTC fields in nine stages of constant-reciprocal
// division and table search. Depends on escc_pkg.
module escc_decode (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [32:0]         i_epoch,
    output logic                o_ok,
    output escc_pkg::t_dec_res  o_res
);

    logic [40:0] p_day;
    logic [24:0] day_sub;
    logic        fix_day;
    logic [10:0] sod_hi;
    logic [15:0] wsum;
    logic [21:0] p_quad;
    logic [22:0] p_hour;
    logic [29:0] p_week;
    logic        fix_quad;
    logic        fix_hour;
    logic        fix_week;
    logic [11:0] rq_adj;
    logic [12:0] rh_adj;
    logic [3:0]  rw_adj;
    logic [1:0]  yidx;
    logic [10:0] ybase;
    logic [18:0] p_min;
    logic [3:0]  mon;
    logic [8:0]  dom_full;
    logic        fix_min;
    logic [6:0]  rm_adj;

    logic        r1_ok, r2_ok, r3_ok, r4_ok, r5_ok, r6_ok, r7_ok, r8_ok, r9_ok;
    logic [24:0] r1_x;
    logic [15:0] r1_q, r2_q;
    logic [6:0]  r1_lo, r2_lo;
    logic [10:0] r2_t;
    logic [15:0] r3_days, r4_days;
    logic [16:0] r3_sod, r4_sod;
    logic [15:0] r4_w;
    logic [5:0]  r4_qq, r5_qq;
    logic [5:0]  r4_qh, r5_qh;
    logic [13:0] r4_qw;
    logic [11:0] r5_rq;
    logic [12:0] r5_rh;
    logic [3:0]  r5_rw;
    logic [5:0]  r6_quads;
    logic [10:0] r6_qday;
    logic [4:0]  r6_hour, r7_hour, r8_hour;
    logic [11:0] r6_shr, r7_shr;
    logic [2:0]  r6_wd, r7_wd, r8_wd;
    logic [7:0]  r7_year, r8_year;
    logic [8:0]  r7_yday, r8_yday;
    logic        r7_leap, r8_leap;
    logic [5:0]  r7_qm, r8_qm;
    logic [3:0]  r8_mon;
    logic [6:0]  r8_rm;
    escc_pkg::t_dec_res r9_res;

    always_comb begin
        p_day    = 41'(i_epoch[31:7]) * 41'(escc_pkg::DAY_RCP);
        day_sub  = r1_x - 25'(25'(r1_q) * 25'(escc_pkg::DAY_SECS_HI));
        fix_day  = (r2_t >= 11'(escc_pkg::DAY_SECS_HI));
        sod_hi   = fix_day ? (r2_t - 11'(escc_pkg::DAY_SECS_HI)) : r2_t;
        wsum     = r3_days + 16'(escc_pkg::EPOCH_WEEKDAY);
        p_quad   = 22'(r3_days) * 22'(escc_pkg::QUAD_RCP);
        p_hour   = 23'(r3_sod) * 23'(escc_pkg::HOUR_RCP);
        p_week   = 30'(wsum) * 30'(escc_pkg::WEEK_RCP);
        fix_quad = (r5_rq >= 12'(escc_pkg::QUAD_DAYS));
        fix_hour = (r5_rh >= 13'(escc_pkg::HOUR_SECS));
        fix_week = (r5_rw >= 4'(escc_pkg::WEEK_DAYS));
        rq_adj   = fix_quad ? (r5_rq - 12'(escc_pkg::QUAD_DAYS)) : r5_rq;
        rh_adj   = fix_hour ? (r5_rh - 13'(escc_pkg::HOUR_SECS)) : r5_rh;
        rw_adj   = fix_week ? (r5_rw - 4'(escc_pkg::WEEK_DAYS)) : r5_rw;
        if (r6_qday >= escc_pkg::LEAP_END_DAYS) begin
            yidx  = 2'd3;
            ybase = escc_pkg::LEAP_END_DAYS;
        end else if (r6_qday >= escc_pkg::TWO_YEAR_DAYS) begin
            yidx  = 2'd2;
            ybase = escc_pkg::TWO_YEAR_DAYS;
        end else if (r6_qday >= 11'(escc_pkg::YEAR_DAYS)) begin
            yidx  = 2'd1;
            ybase = 11'(escc_pkg::YEAR_DAYS);
        end else begin
            yidx  = 2'd0;
            ybase = 11'd0;
        end
        p_min = 19'(r6_shr) * 19'(escc_pkg::MIN_RCP);
        mon   = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (escc_pkg::days_before(4'(m), r7_leap) <= r7_yday) begin
                mon = 4'(m);
            end
        end
        dom_full = r8_yday - escc_pkg::days_before(r8_mon, r8_leap) + 9'd1;
        fix_min  = (r8_rm >= 7'(escc_pkg::MIN_SECS));
        rm_adj   = fix_min ? (r8_rm - 7'(escc_pkg::MIN_SECS)) : r8_rm;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // divide by a day
            r1_ok    <= !i_epoch[32];
            r1_x     <= i_epoch[31:7];
            r1_lo    <= i_epoch[6:0];
            r1_q     <= p_day[40:25];
            r2_ok    <= r1_ok;
            r2_q     <= r1_q;
            r2_lo    <= r1_lo;
            r2_t     <= day_sub[10:0];
            r3_ok    <= r2_ok;
            r3_days  <= r2_q + 16'(fix_day);
            r3_sod   <= {sod_hi[9:0], r2_lo};
            // four-year block, hour and weekday
            r4_ok    <= r3_ok;
            r4_days  <= r3_days;
            r4_sod   <= r3_sod;
            r4_w     <= wsum;
            r4_qq    <= p_quad[21:16];
            r4_qh    <= p_hour[22:17];
            r4_qw    <= p_week[29:16];
            r5_ok    <= r4_ok;
            r5_qq    <= r4_qq;
            r5_qh    <= r4_qh;
            r5_rq    <= 12'(r4_days - 16'(16'(r4_qq) * 16'(escc_pkg::QUAD_DAYS)));
            r5_rh    <= 13'(r4_sod - 17'(17'(r4_qh) * 17'(escc_pkg::HOUR_SECS)));
            r5_rw    <= 4'(r4_w - 16'(16'(r4_qw) * 16'(escc_pkg::WEEK_DAYS)));
            r6_ok    <= r5_ok;
            r6_quads <= r5_qq + 6'(fix_quad);
            r6_qday  <= rq_adj[10:0];
            r6_hour  <= 5'(r5_qh + 6'(fix_hour));
            r6_shr   <= rh_adj[11:0];
            r6_wd    <= rw_adj[2:0];
            // year within block, minute estimate
            r7_ok    <= r6_ok;
            r7_year  <= {r6_quads, 2'b00} + escc_pkg::BASE_YEAR + 8'(yidx);
            r7_yday  <= 9'(r6_qday - ybase);
            r7_leap  <= (yidx == escc_pkg::LEAP_SLOT);
            r7_qm    <= p_min[17:12];
            r7_shr   <= r6_shr;
            r7_hour  <= r6_hour;
            r7_wd    <= r6_wd;
            // month search
            r8_ok    <= r7_ok;
            r8_mon   <= mon;
            r8_rm    <= 7'(r7_shr - 12'(12'(r7_qm) * 12'(escc_pkg::MIN_SECS)));
            r8_qm    <= r7_qm;
            r8_year  <= r7_year;
            r8_yday  <= r7_yday;
            r8_leap  <= r7_leap;
            r8_hour  <= r7_hour;
            r8_wd    <= r7_wd;
            r9_ok                   <= r8_ok;
            r9_res.years_since_1900 <= r8_year;
            r9_res.month_index      <= r8_mon;
            r9_res.day_of_month     <= dom_full[4:0];
            r9_res.day_of_year      <= r8_yday;
            r9_res.weekday          <= r8_wd;
            r9_res.hour_out         <= r8_hour;
            r9_res.minute_out       <= r8_qm + 6'(fix_min);
            r9_res.second_out       <= rm_adj[5:0];
        end
    end

    assign o_ok  = r9_ok;
    assign o_res = r9_res;

endmodule
